>>> rtl/core/dpd_pkg.sv
// Shared types, character codes and helpers for the debugger packet deframer.
`default_nettype none
package dpd_pkg;

  localparam int MAX_PACKET = 256;
  localparam int POS_W      = $clog2(MAX_PACKET + 2);

  localparam logic [2:0] EV_START   = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_PEND    = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_BREAK   = 3'd4;
  localparam logic [2:0] EV_HEADER  = 3'd5;
  localparam logic [2:0] EV_BINARY  = 3'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BREAK  = 8'h03;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [1:0] CK_IDLE   = 2'd0;
  localparam logic [1:0] CK_FIRST  = 2'd1;
  localparam logic [1:0] CK_SECOND = 2'd2;

  typedef struct packed {
    logic        last_binary;
    logic [7:0]  check_low;
    logic [7:0]  check_high;
    logic [31:0] byte_count;
    logic [31:0] target_address;
    logic        overflow;
    logic [7:0]  position;
    logic [7:0]  data_byte;
    logic [2:0]  event_kind;
    logic        last;
  } evt_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = c[3:0];
    if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] sat_pos(input logic [POS_W-1:0] p);
    logic [7:0] r;
    r = (p > POS_W'(255)) ? 8'hFF : p[7:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/debug_packet_deframer.sv
// Deframer for debugger serial packets of the form $payload#cc.
//
// The in_ stream carries one received serial byte per beat. The out_ stream
// carries events: out_tuser holds the event kind, out_tdata the event fields,
// and out_tlast marks the last event caused by one input byte. Each byte gives
// zero, one or two events.
// A byte is held in an input register, decoded against the
// framing state, and its events are written into a four-entry output queue.
// The events of a byte pass from the input register into the queue, whose head
// is offered on the out_ side; a full queue can hold a byte in between.
// One byte is accepted per cycle while the queue has room for two events, so
// a stream of single-event bytes runs at one beat per cycle; a byte with two
// events puts both into the queue, which drains them in order.
// When the receiver stalls, the queue fills and in_tready drops until it has
// room for two events again; nothing is lost or repeated.
// A synchronous reset (rst_n low) empties the queue and the input register and
// clears all framing state, so the block waits for a new packet start.
`default_nettype none
module debug_packet_deframer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // rx_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // data_byte, position, overflow,
                                        // target_address, byte_count,
                                        // check_high, check_low, last_binary
  output logic [2:0]        out_tuser,  // event_kind
  output logic              out_tlast
);

  localparam int PW = dpd_pkg::POS_W;

  logic              in_valid_r;
  logic [7:0]        byte_r;
  logic              proc;

  logic              in_pkt_r, in_pkt_nxt;
  logic [1:0]        ck_phase_r, ck_phase_nxt;
  logic [7:0]        first_ck_r, first_ck_nxt;
  logic              hdr_r, hdr_nxt;
  logic              cnt_phase_r, cnt_phase_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [31:0]       addr_acc_r, addr_acc_nxt;
  logic [31:0]       cnt_acc_r, cnt_acc_nxt;
  logic              gath_r, gath_nxt;
  logic [31:0]       rcv_r, rcv_nxt;

  dpd_pkg::evt_t     ev_done;
  dpd_pkg::evt_t     ev_main;
  logic              have_done;
  logic              have_main;

  dpd_pkg::evt_t     q_r [4];
  logic [1:0]        wr_ptr_r;
  logic [1:0]        rd_ptr_r;
  logic [2:0]        q_cnt_r;
  logic [1:0]        push_n;
  logic              pop;
  dpd_pkg::evt_t     wr_first;
  dpd_pkg::evt_t     wr_second;

  assign proc      = in_valid_r && (q_cnt_r <= 3'd2);
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  always_comb begin
    logic [31:0] rc_inc;
    in_pkt_nxt    = in_pkt_r;
    ck_phase_nxt  = ck_phase_r;
    first_ck_nxt  = first_ck_r;
    hdr_nxt       = hdr_r;
    cnt_phase_nxt = cnt_phase_r;
    pos_nxt       = pos_r;
    addr_acc_nxt  = addr_acc_r;
    cnt_acc_nxt   = cnt_acc_r;
    gath_nxt      = gath_r;
    rcv_nxt       = rcv_r;
    ev_done       = '0;
    ev_main       = '0;
    have_done     = 1'b0;
    have_main     = 1'b0;
    rc_inc        = rcv_r + 32'd1;

    if (gath_r) begin
      rcv_nxt                = rc_inc;
      have_main              = 1'b1;
      ev_main.event_kind     = dpd_pkg::EV_BINARY;
      ev_main.data_byte      = byte_r;
      ev_main.target_address = addr_acc_r + rcv_r;
      ev_main.last_binary    = (rc_inc == cnt_acc_r);
      if (rc_inc == cnt_acc_r) begin
        gath_nxt = 1'b0;
      end
    end else if (!hdr_r && byte_r == dpd_pkg::CH_BREAK) begin
      have_main          = 1'b1;
      ev_main.event_kind = dpd_pkg::EV_BREAK;
    end else begin
      if (ck_phase_r == dpd_pkg::CK_FIRST) begin
        first_ck_nxt = byte_r;
        ck_phase_nxt = dpd_pkg::CK_SECOND;
      end else if (ck_phase_r != dpd_pkg::CK_IDLE) begin
        have_done          = 1'b1;
        ev_done.event_kind = dpd_pkg::EV_DONE;
        ev_done.check_high = first_ck_r;
        ev_done.check_low  = byte_r;
        ck_phase_nxt       = dpd_pkg::CK_IDLE;
      end

      if (hdr_r && byte_r == dpd_pkg::CH_COLON) begin
        have_main              = 1'b1;
        ev_main.event_kind     = dpd_pkg::EV_HEADER;
        ev_main.target_address = addr_acc_r;
        ev_main.byte_count     = cnt_acc_r;
        rcv_nxt                = '0;
        hdr_nxt                = 1'b0;
        gath_nxt               = (cnt_acc_r != 32'd0);
        if (in_pkt_r && pos_r <= PW'(dpd_pkg::MAX_PACKET)) begin
          pos_nxt = pos_r + PW'(1);
        end
      end else if (in_pkt_r && byte_r != dpd_pkg::CH_HASH && byte_r != dpd_pkg::CH_DOLLAR) begin
        if (hdr_r) begin
          if (!cnt_phase_r && byte_r == dpd_pkg::CH_COMMA) begin
            cnt_phase_nxt = 1'b1;
          end else if (cnt_phase_r) begin
            cnt_acc_nxt = {cnt_acc_r[27:0], dpd_pkg::hex_value(byte_r)};
          end else begin
            addr_acc_nxt = {addr_acc_r[27:0], dpd_pkg::hex_value(byte_r)};
          end
        end
        if (byte_r == dpd_pkg::CH_X && pos_r == '0) begin
          hdr_nxt = 1'b1;
        end
        have_main          = 1'b1;
        ev_main.event_kind = dpd_pkg::EV_PAYLOAD;
        ev_main.data_byte  = byte_r;
        ev_main.position   = dpd_pkg::sat_pos(pos_r);
        ev_main.overflow   = (pos_r >= PW'(dpd_pkg::MAX_PACKET));
        if (pos_r <= PW'(dpd_pkg::MAX_PACKET)) begin
          pos_nxt = pos_r + PW'(1);
        end
      end

      if (in_pkt_r && byte_r == dpd_pkg::CH_HASH) begin
        have_main          = 1'b1;
        ev_main.event_kind = dpd_pkg::EV_PEND;
        ev_main.position   = dpd_pkg::sat_pos(pos_r);
        ev_main.overflow   = (pos_r > PW'(dpd_pkg::MAX_PACKET));
        ck_phase_nxt       = dpd_pkg::CK_FIRST;
        in_pkt_nxt         = 1'b0;
      end

      if (byte_r == dpd_pkg::CH_DOLLAR) begin
        pos_nxt            = '0;
        in_pkt_nxt         = 1'b1;
        hdr_nxt            = 1'b0;
        cnt_phase_nxt      = 1'b0;
        addr_acc_nxt       = '0;
        cnt_acc_nxt        = '0;
        have_main          = 1'b1;
        ev_main.event_kind = dpd_pkg::EV_START;
      end
    end

    ev_done.last = !have_main;
    ev_main.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pkt_r    <= 1'b0;
      ck_phase_r  <= dpd_pkg::CK_IDLE;
      first_ck_r  <= '0;
      hdr_r       <= 1'b0;
      cnt_phase_r <= 1'b0;
      pos_r       <= '0;
      addr_acc_r  <= '0;
      cnt_acc_r   <= '0;
      gath_r      <= 1'b0;
      rcv_r       <= '0;
    end else if (proc) begin
      in_pkt_r    <= in_pkt_nxt;
      ck_phase_r  <= ck_phase_nxt;
      first_ck_r  <= first_ck_nxt;
      hdr_r       <= hdr_nxt;
      cnt_phase_r <= cnt_phase_nxt;
      pos_r       <= pos_nxt;
      addr_acc_r  <= addr_acc_nxt;
      cnt_acc_r   <= cnt_acc_nxt;
      gath_r      <= gath_nxt;
      rcv_r       <= rcv_nxt;
    end
  end

  // A completion event always precedes the other event of the same byte.
  assign wr_first  = have_done ? ev_done : ev_main;
  assign wr_second = ev_main;
  assign push_n    = proc ? ({1'b0, have_done} + {1'b0, have_main}) : 2'd0;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      q_cnt_r  <= q_cnt_r + {1'b0, push_n} - {2'b00, pop};
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= wr_first;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= wr_second;
    end
  end

  assign out_tvalid = (q_cnt_r != 3'd0);
  assign out_tuser  = q_r[rd_ptr_r].event_kind;
  assign out_tlast  = q_r[rd_ptr_r].last;
  assign out_tdata  = {6'b0,
                       q_r[rd_ptr_r].last_binary,
                       q_r[rd_ptr_r].check_low,
                       q_r[rd_ptr_r].check_high,
                       q_r[rd_ptr_r].byte_count,
                       q_r[rd_ptr_r].target_address,
                       q_r[rd_ptr_r].overflow,
                       q_r[rd_ptr_r].position,
                       q_r[rd_ptr_r].data_byte};

endmodule
`default_nettype wire

>>> test/dpd_event_checker.sv
// Watches both streams of the deframer, predicts each byte's events and compares them.
module dpd_event_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [103:0] out_tdata,
  input  wire logic [2:0]   out_tuser,
  input  wire logic         out_tlast,
  output int                fail_count,
  output int                pending,
  output int                events_seen,
  output int                headers_seen,
  output int                binary_seen,
  output int                overflow_seen
);
  import dpd_pkg::*;

  evt_t expected_events[$];

  logic             in_pkt;
  logic [1:0]       ck_phase;
  logic [7:0]       first_chk;
  logic             hdr_active;
  logic             hdr_count;
  logic [POS_W-1:0] pkt_pos;
  logic [31:0]      base_addr;
  logic [31:0]      xfer_count;
  logic [31:0]      xfer_done;
  logic             gathering;

  int fails;
  int results_n;
  int headers_n;
  int binary_n;
  int overflow_n;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    t = c;
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  function automatic logic [7:0] clip_pos(input logic [POS_W-1:0] p);
    return (p > 255) ? 8'hFF : p[7:0];
  endfunction

  function automatic evt_t make_evt(input logic [2:0] kind);
    evt_t e;
    e = '0;
    e.event_kind = kind;
    return e;
  endfunction

  function automatic string evt_text(input evt_t e);
    string s;
    s = $sformatf("kind=%0d data=%02h pos=%0d ovf=%0b addr=%08h",
                  e.event_kind, e.data_byte, e.position, e.overflow, e.target_address);
    return {s, $sformatf(" cnt=%08h chk=%02h/%02h lastbin=%0b last=%0b",
                         e.byte_count, e.check_high, e.check_low, e.last_binary, e.last)};
  endfunction

  task automatic clear_state();
    in_pkt     = 1'b0;
    ck_phase   = CK_IDLE;
    first_chk  = 8'h00;
    hdr_active = 1'b0;
    hdr_count  = 1'b0;
    pkt_pos    = '0;
    base_addr  = '0;
    xfer_count = '0;
    xfer_done  = '0;
    gathering  = 1'b0;
  endtask

  // Works out the events one received byte causes and queues them in order.
  task automatic deframe_byte(input logic [7:0] b);
    evt_t             batch [0:1];
    evt_t             e;
    int               n;
    logic [POS_W-1:0] p;
    n = 0;
    if (gathering) begin
      e = make_evt(EV_BINARY);
      e.data_byte = b;
      e.target_address = base_addr + xfer_done;
      xfer_done = xfer_done + 1;
      if (xfer_done == xfer_count) begin
        gathering = 1'b0;
        e.last_binary = 1'b1;
      end
      batch[n] = e;
      n++;
    end else if (!hdr_active && b == CH_BREAK) begin
      batch[n] = make_evt(EV_BREAK);
      n++;
    end else begin
      if (ck_phase == CK_FIRST) begin
        first_chk = b;
        ck_phase = CK_SECOND;
      end else if (ck_phase != CK_IDLE) begin
        e = make_evt(EV_DONE);
        e.check_high = first_chk;
        e.check_low = b;
        batch[n] = e;
        n++;
        ck_phase = CK_IDLE;
      end

      if (hdr_active && b == CH_COLON) begin
        e = make_evt(EV_HEADER);
        e.target_address = base_addr;
        e.byte_count = xfer_count;
        batch[n] = e;
        n++;
        xfer_done = '0;
        hdr_active = 1'b0;
        gathering = (xfer_count != 0);
        if (in_pkt && pkt_pos <= MAX_PACKET) pkt_pos = pkt_pos + 1'b1;
      end else if (in_pkt && b != CH_HASH && b != CH_DOLLAR) begin
        p = pkt_pos;
        if (hdr_active) begin
          if (!hdr_count && b == CH_COMMA) begin
            hdr_count = 1'b1;
          end else if (hdr_count) begin
            xfer_count = {xfer_count[27:0], nibble_of(b)};
          end else begin
            base_addr = {base_addr[27:0], nibble_of(b)};
          end
        end
        if (b == CH_X && p == 0) hdr_active = 1'b1;
        e = make_evt(EV_PAYLOAD);
        e.data_byte = b;
        e.position = clip_pos(p);
        e.overflow = (p >= MAX_PACKET);
        batch[n] = e;
        n++;
        if (p <= MAX_PACKET) pkt_pos = p + 1'b1;
      end

      if (in_pkt && b == CH_HASH) begin
        e = make_evt(EV_PEND);
        e.position = clip_pos(pkt_pos);
        e.overflow = (pkt_pos > MAX_PACKET);
        batch[n] = e;
        n++;
        ck_phase = CK_FIRST;
        in_pkt = 1'b0;
      end

      if (b == CH_DOLLAR) begin
        pkt_pos = '0;
        in_pkt = 1'b1;
        hdr_active = 1'b0;
        hdr_count = 1'b0;
        base_addr = '0;
        xfer_count = '0;
        batch[n] = make_evt(EV_START);
        n++;
      end
    end

    for (int i = 0; i < n; i++) begin
      e = batch[i];
      e.last = (i == n - 1);
      expected_events.push_back(e);
    end
  endtask

  task automatic check_result(input evt_t got);
    evt_t want;
    logic ok;
    results_n++;
    if (got.event_kind == EV_HEADER) headers_n++;
    if (got.event_kind == EV_BINARY) binary_n++;
    if (got.overflow) overflow_n++;
    if (expected_events.size() == 0) begin
      fails++;
      if (fails <= 10) $display("Unexpected event %0d: %s", results_n, evt_text(got));
    end else begin
      want = expected_events.pop_front();
      ok = (got.event_kind == want.event_kind) && (got.data_byte == want.data_byte) &&
           (got.position == want.position) && (got.overflow == want.overflow) &&
           (got.target_address == want.target_address) &&
           (got.byte_count == want.byte_count) && (got.check_high == want.check_high) &&
           (got.check_low == want.check_low) && (got.last_binary == want.last_binary) &&
           (got.last == want.last);
      if (!ok) begin
        fails++;
        if (fails <= 10) begin
          $display("Event %0d mismatch", results_n);
          $display("  expected %s", evt_text(want));
          $display("  actual   %s", evt_text(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    evt_t got;
    if (!rst_n) begin
      clear_state();
      expected_events.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '0;
        got.data_byte      = out_tdata[7:0];
        got.position       = out_tdata[15:8];
        got.overflow       = out_tdata[16];
        got.target_address = out_tdata[48:17];
        got.byte_count     = out_tdata[80:49];
        got.check_high     = out_tdata[88:81];
        got.check_low      = out_tdata[96:89];
        got.last_binary    = out_tdata[97];
        got.event_kind     = out_tuser;
        got.last           = out_tlast;
        check_result(got);
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    fail_count    <= fails;
    pending       <= expected_events.size();
    events_seen   <= results_n;
    headers_seen  <= headers_n;
    binary_seen   <= binary_n;
    overflow_seen <= overflow_n;
  end

endmodule

>>> test/tb_top.sv
// Top of the deframer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module tb_top;
  import dpd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_PAYLOAD = 300;
  localparam int HOLD_CYCLES  = 400;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [7:0]   in_tdata   = 8'h00;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [103:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  int fail_count;
  int pending;
  int events_seen;
  int headers_seen;
  int binary_seen;
  int overflow_seen;

  logic [7:0] stream[$];
  int         calm_tx = 0;
  int         calm_rx = 0;
  int         idle_cycles = 0;

  debug_packet_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dpd_event_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .events_seen   (events_seen),
    .headers_seen  (headers_seen),
    .binary_seen   (binary_seen),
    .overflow_seen (overflow_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + v;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_DOLLAR || b == CH_HASH || b == CH_X) b = 8'h61 + 8'($urandom_range(0, 25));
    return b;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return CH_DOLLAR;
      1: return CH_HASH;
      2: return CH_BREAK;
      3: return CH_COLON;
      4: return CH_COMMA;
      default: return text_byte();
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 3))
      0: return CH_BREAK;
      1: return 8'h67;
      2: return 8'h78;
      default: return 8'h20;
    endcase
  endfunction

  task automatic put(input logic [7:0] b);
    stream.push_back(b);
  endtask

  task automatic put_checksum();
    repeat (2) put(($urandom_range(0, 7) == 0) ? text_byte() : hex_char(4'($urandom_range(0, 15))));
  endtask

  task automatic add_text_packet(input int len);
    put(CH_DOLLAR);
    repeat (len) put(text_byte());
    put(CH_HASH);
    put_checksum();
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (calm_tx > 0) begin
      calm_tx = calm_tx - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_tx = $urandom_range(20, 80);
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : rx_side
    int gap;
    int beats;
    beats = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = 0;
      if (beats == 200) begin
        gap = HOLD_CYCLES;
      end else if (calm_rx > 0) begin
        calm_rx = calm_rx - 1;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_rx = $urandom_range(20, 80);
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      beats++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("debug_packet_deframer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  r;
    int  cnt;
    bit  long_done;
    long_done = 1'b0;

    // Break, binary header with a junk digit, data holding framing bytes, then
    // restart, byte extremes and a header with a zero count.
    put(CH_BREAK);  put(CH_DOLLAR); put(CH_X);     put(8'h30);    put(8'h78);
    put(CH_COMMA);  put(8'h33);     put(CH_COLON);
    put(CH_DOLLAR); put(CH_BREAK);  put(CH_HASH);
    put(CH_X);      put(CH_HASH);   put(8'h41);    put(8'h62);
    put(CH_DOLLAR); put(8'h61);     put(CH_DOLLAR); put(8'h00);   put(8'hFF);
    put(CH_HASH);   put(8'h31);     put(8'h32);
    put(CH_DOLLAR); put(CH_X);      put(CH_COLON); put(CH_HASH);

    while (stream.size() < 800) begin
      if (!long_done && stream.size() > 400) begin
        add_text_packet(LONG_PAYLOAD);
        long_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        add_text_packet($urandom_range(0, 20));
      end else if (r < 75) begin
        put(CH_DOLLAR);
        put(CH_X);
        repeat ($urandom_range(1, 10)) begin
          put(($urandom_range(0, 7) == 0) ? junk_char() : hex_char(4'($urandom_range(0, 15))));
        end
        put(CH_COMMA);
        cnt = $urandom_range(0, 12);
        r = $urandom_range(0, 9);
        // A stray leading digit is shifted out of the 32-bit count again.
        if (r < 2) begin
          put((r == 0) ? CH_COMMA : junk_char());
          repeat (7) put(8'h30);
        end else begin
          repeat ($urandom_range(0, 2)) put(8'h30);
        end
        put(hex_char(4'(cnt)));
        put(CH_COLON);
        repeat (cnt) put(($urandom_range(0, 3) == 0) ? noise_char() : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) put(text_byte());
        put(CH_HASH);
        put_checksum();
      end else if (r < 88) begin
        put(CH_DOLLAR);
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(0, 5)) put(text_byte());
          put(CH_DOLLAR);
        end else begin
          put(CH_X);
          repeat ($urandom_range(0, 4)) put(hex_char(4'($urandom_range(0, 15))));
          if ($urandom_range(0, 1) == 0) begin
            put(CH_COMMA);
            put(hex_char(4'($urandom_range(0, 12))));
          end
          put(CH_HASH);
          put_checksum();
          if ($urandom_range(0, 1) == 0) put(CH_COLON);
        end
      end else begin
        repeat ($urandom_range(1, 6)) put(noise_char());
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stream[i]) send_byte(stream[i]);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes: framing corner cases, random text and binary-transfer packets,",
             stream.size());
    $display("broken headers and noise; checked %0d events (%0d headers, %0d binary, %0d overflow).",
             events_seen, headers_seen, binary_seen, overflow_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("debug_packet_deframer test passed");
    end else begin
      $display("debug_packet_deframer test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dpd_pkg.sv
rtl/core/debug_packet_deframer.sv
test/dpd_event_checker.sv
test/tb_top.sv
